// ----- hw/rtl/pfra_pkg.sv -----
// Package: shared types, codes and sizes for the page frame allocator.
package pfra_pkg;

  localparam int FRAMES    = 4096;
  localparam int ADDR_W    = $clog2(FRAMES);
  localparam int IDX_W     = ADDR_W + 1;
  localparam int MAX_RUN   = 16;
  localparam int ENTRY_W   = 8;
  localparam int FRAME_W   = 20;
  localparam int RUN_W     = 5;
  localparam int CNT_W     = 7;
  localparam int COW_BIT   = 7;
  localparam logic [CNT_W-1:0] USER_LIMIT = 7'd127;

  // Request kinds.
  localparam logic [2:0] KIND_ALLOC   = 3'd0;
  localparam logic [2:0] KIND_FREE    = 3'd1;
  localparam logic [2:0] KIND_ADDREF  = 3'd2;
  localparam logic [2:0] KIND_MARK    = 3'd3;
  localparam logic [2:0] KIND_QUERY   = 3'd4;
  localparam logic [2:0] KIND_RESERVE = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_RUN    = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_UNUSED    = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  // Configuration register indexes.
  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic [2:0]         kind;
    logic [FRAME_W-1:0] frame_number;
    logic [RUN_W-1:0]   run_length;
    logic               cow_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [FRAME_W-1:0] result_frame;
    logic [CNT_W-1:0]   user_count;
    logic               cow_flag;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_CLEAR, CMD_IDLE, CMD_DISPATCH, CMD_SCAN_RD, CMD_SCAN_EV, CMD_FILL,
    CMD_CHK_RD, CMD_CHK_EV, CMD_MOD_RD, CMD_MOD_WR, CMD_QRY_RD, CMD_QRY_EV,
    CMD_RESV, CMD_DONE
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] kind;
    logic       reject;
    logic       scan_end;
    logic       found;
    logic       k_last;
    logic       chk_err;
    logic       clear_last;
  } dp_stat_t;

endpackage

// ----- hw/rtl/page_frame_refcount_allocator_unit.sv -----
// Top level of the page frame allocator with reference counts.
// After reset the unit clears its 4096-entry frame table, one entry per cycle,
// and holds busy high while it does so; configuration writes are taken
// at any time. A request is taken when start is high and busy is low, and its
// single result appears on rsp for exactly one cycle with done high; the
// receiver cannot stall it. Each table read passes through a read state and an
// evaluate state of the single-read-port frame table; free, add-reference and
// mark first check the whole run and then update it (stopping early on an
// error), and alloc scans from the search hint before filling the run.
module page_frame_refcount_allocator_unit import pfra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t     cmd;
  dp_stat_t stat;

  // Sequencer.
  pfra_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  // Table, pointers and registers.
  pfra_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .rsp    (rsp),
    .stat   (stat),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata)
  );

  assign pready = 1'b1;

endmodule

// ----- hw/rtl/pfra_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pfra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/pfra_datapath.sv -----
// Datapath: frame table, search pointers, configuration registers and result.
module pfra_datapath import pfra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  req_t        req,
  output rsp_t        rsp,
  output dp_stat_t    stat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata
);

  req_t               cur;
  logic [FRAME_W-1:0] base_frame;
  logic [12:0]        page_count;
  logic [IDX_W-1:0]   hint;
  logic [IDX_W-1:0]   ptr;
  logic [IDX_W-1:0]   run_start;
  logic [RUN_W-1:0]   cnt;
  logic               first;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [ENTRY_W-1:0] rdata;

  logic [RUN_W-1:0]   r_eff;
  logic [IDX_W-1:0]   n;
  logic [FRAME_W-1:0] off;
  logic               off_bad;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  kaddr;
  logic [CNT_W-1:0]   ucnt;
  logic [CNT_W-1:0]   udec;
  logic [IDX_W-1:0]   start_now;
  logic               cnt_last;

  pfra_ram #(.WIDTH(ENTRY_W), .DEPTH(FRAMES)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Request decode and range checks.
  assign r_eff   = (cur.kind == KIND_QUERY) ? RUN_W'(1) : cur.run_length;
  assign n       = (page_count > 13'(FRAMES)) ? IDX_W'(FRAMES) : IDX_W'(page_count);
  assign off     = cur.frame_number - base_frame;
  assign off_bad = (cur.frame_number < base_frame) || (off >= FRAME_W'(n)) ||
                   ({1'b0, off} + (FRAME_W+1)'(r_eff) > (FRAME_W+1)'(n));
  assign idx     = off[ADDR_W-1:0];
  assign kaddr   = idx + ADDR_W'(cnt);
  assign ucnt    = rdata[CNT_W-1:0];
  assign udec    = ucnt - CNT_W'(1);
  assign start_now = (cnt == '0) ? ptr : run_start;
  assign cnt_last  = (cnt + RUN_W'(1)) == r_eff;

  always_comb begin
    stat.kind       = cur.kind;
    stat.reject     = (cur.kind > KIND_RESERVE) || (r_eff == '0) ||
                      (r_eff > RUN_W'(MAX_RUN)) || ((cur.kind != KIND_ALLOC) && off_bad);
    stat.scan_end   = (cnt == '0) &&
                      ((IDX_W+1)'(ptr) + (IDX_W+1)'(r_eff) > (IDX_W+1)'(n));
    stat.found      = (rdata == '0) && cnt_last;
    stat.k_last     = cnt_last;
    stat.chk_err    = (ucnt == '0) || ((cur.kind == KIND_ADDREF) && (ucnt == USER_LIMIT));
    stat.clear_last = (ptr[ADDR_W-1:0] == '1);
  end

  // Table port control for each command.
  always_comb begin
    we    = 1'b0;
    waddr = kaddr;
    wdata = '0;
    raddr = kaddr;
    unique case (cmd)
      CMD_CLEAR: begin
        we    = 1'b1;
        waddr = ptr[ADDR_W-1:0];
      end
      CMD_SCAN_RD: raddr = ptr[ADDR_W-1:0];
      CMD_FILL: begin
        we    = 1'b1;
        waddr = ptr[ADDR_W-1:0];
        wdata = ENTRY_W'(1);
      end
      CMD_MOD_WR: begin
        we = 1'b1;
        if (cur.kind == KIND_FREE) begin
          wdata = (udec == '0) ? '0 : {rdata[COW_BIT], udec};
        end else if (cur.kind == KIND_ADDREF) begin
          wdata = rdata + ENTRY_W'(1);
        end else begin
          wdata = {cur.cow_value, rdata[CNT_W-1:0]};
        end
      end
      CMD_RESV: begin
        we    = 1'b1;
        wdata = {1'b0, USER_LIMIT};
      end
      default: ;
    endcase
  end

  // Control registers: pointers, counters, hint.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      cnt   <= '0;
      first <= 1'b1;
      hint  <= '0;
    end else begin
      unique case (cmd)
        CMD_CLEAR: ptr <= ptr + IDX_W'(1);
        CMD_DISPATCH: begin
          ptr   <= hint;
          cnt   <= '0;
          first <= 1'b1;
        end
        CMD_SCAN_EV: begin
          if (rdata == '0) begin
            if (cnt_last) begin
              ptr <= start_now;
              cnt <= '0;
            end else begin
              ptr <= ptr + IDX_W'(1);
              cnt <= cnt + RUN_W'(1);
            end
          end else begin
            if (cnt != '0) begin
              first <= 1'b0;
            end
            ptr <= ptr + IDX_W'(1);
            cnt <= '0;
          end
        end
        CMD_FILL: begin
          ptr <= ptr + IDX_W'(1);
          cnt <= cnt + RUN_W'(1);
          if (cnt_last && first) begin
            hint <= run_start + IDX_W'(r_eff);
          end
        end
        CMD_CHK_EV: cnt <= cnt_last ? '0 : cnt + RUN_W'(1);
        CMD_MOD_WR: begin
          cnt <= cnt + RUN_W'(1);
          if ((cur.kind == KIND_FREE) && (udec == '0) && (hint > IDX_W'(kaddr))) begin
            hint <= IDX_W'(kaddr);
          end
        end
        CMD_RESV: cnt <= cnt + RUN_W'(1);
        default: ;
      endcase
    end
  end

  // Request capture, run start and result register.
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_IDLE: begin
        cur <= req;
        rsp <= '0;
      end
      CMD_DISPATCH: begin
        if (stat.reject) begin
          rsp.status <= ST_RANGE;
        end
      end
      CMD_SCAN_RD: begin
        if (stat.scan_end) begin
          rsp.status <= ST_NO_RUN;
        end
      end
      CMD_SCAN_EV: begin
        if ((rdata == '0) && (cnt == '0)) begin
          run_start <= ptr;
        end
      end
      CMD_FILL: rsp.result_frame <= base_frame + FRAME_W'(run_start);
      CMD_CHK_EV: begin
        if (ucnt == '0) begin
          rsp.status <= ST_UNUSED;
        end else if (stat.chk_err) begin
          rsp.status <= ST_SATURATED;
        end
      end
      CMD_QRY_EV: begin
        rsp.user_count <= ucnt;
        rsp.cow_flag   <= rdata[COW_BIT];
      end
      default: ;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame <= '0;
      page_count <= 13'(FRAMES);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BASE) begin
        base_frame <= pwdata[FRAME_W-1:0];
      end else begin
        page_count <= pwdata[12:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_COUNT) ? 32'(page_count) : 32'(base_frame);

endmodule

// ----- hw/rtl/pfra_ctrl.sv -----
// Controller: sequences clearing, search, check, update, query and reserve passes.
module pfra_ctrl import pfra_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output cmd_t     cmd,
  output logic     busy,
  output logic     done
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_EV, S_FILL, S_CHK_RD,
    S_CHK_EV, S_MOD_RD, S_MOD_WR, S_QRY_RD, S_QRY_EV, S_RESV, S_DONE
  } state_t;

  state_t state;

  // State register and transitions.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: if (stat.clear_last) state <= S_IDLE;
        S_IDLE: if (start) state <= S_DISPATCH;
        S_DISPATCH: begin
          if (stat.reject) begin
            state <= S_DONE;
          end else begin
            unique case (stat.kind)
              KIND_ALLOC:   state <= S_SCAN_RD;
              KIND_QUERY:   state <= S_QRY_RD;
              KIND_RESERVE: state <= S_RESV;
              default:      state <= S_CHK_RD;
            endcase
          end
        end
        S_SCAN_RD: state <= stat.scan_end ? S_DONE : S_SCAN_EV;
        S_SCAN_EV: state <= stat.found ? S_FILL : S_SCAN_RD;
        S_FILL:    if (stat.k_last) state <= S_DONE;
        S_CHK_RD:  state <= S_CHK_EV;
        S_CHK_EV: begin
          if (stat.chk_err) begin
            state <= S_DONE;
          end else if (stat.k_last) begin
            state <= S_MOD_RD;
          end else begin
            state <= S_CHK_RD;
          end
        end
        S_MOD_RD:  state <= S_MOD_WR;
        S_MOD_WR:  state <= stat.k_last ? S_DONE : S_MOD_RD;
        S_QRY_RD:  state <= S_QRY_EV;
        S_QRY_EV:  state <= S_DONE;
        S_RESV:    if (stat.k_last) state <= S_DONE;
        S_DONE:    state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

  // Command to the datapath follows the state.
  always_comb begin
    unique case (state)
      S_CLEAR:    cmd = CMD_CLEAR;
      S_IDLE:     cmd = CMD_IDLE;
      S_DISPATCH: cmd = CMD_DISPATCH;
      S_SCAN_RD:  cmd = CMD_SCAN_RD;
      S_SCAN_EV:  cmd = CMD_SCAN_EV;
      S_FILL:     cmd = CMD_FILL;
      S_CHK_RD:   cmd = CMD_CHK_RD;
      S_CHK_EV:   cmd = CMD_CHK_EV;
      S_MOD_RD:   cmd = CMD_MOD_RD;
      S_MOD_WR:   cmd = CMD_MOD_WR;
      S_QRY_RD:   cmd = CMD_QRY_RD;
      S_QRY_EV:   cmd = CMD_QRY_EV;
      S_RESV:     cmd = CMD_RESV;
      default:    cmd = CMD_DONE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ----- sim/tb_page_frame_refcount_allocator_unit.sv -----
// Testbench for the page frame allocator: predicts each result and checks it.
`timescale 1ns / 100ps

module tb_page_frame_refcount_allocator_unit;
  import pfra_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        done;
  rsp_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  page_frame_refcount_allocator_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state of the frame table and registers.
  logic [7:0]         frames_model [FRAMES];
  logic [12:0]        hint_model;
  logic [FRAME_W-1:0] base_model;
  logic [12:0]        count_model;
  rsp_t               pending_rsp [$];
  int                 errors = 0;
  int                 quiet_cycles = 0;

  function automatic int managed();
    return (count_model > FRAMES) ? FRAMES : int'(count_model);
  endfunction

  // Applies one request to the predicted state and returns its result.
  function automatic rsp_t predict_request(req_t q);
    rsp_t o;
    int n, r, i, j, idx;
    bit first, hit;
    logic [6:0] c;
    o = '0;
    n = managed();
    r = q.run_length;
    if (q.kind > KIND_RESERVE) begin
      o.status = ST_RANGE;
      return o;
    end
    if (q.kind == KIND_QUERY) r = 1;
    if (r == 0 || r > MAX_RUN) begin
      o.status = ST_RANGE;
      return o;
    end
    if (q.kind == KIND_ALLOC) begin
      first = 1'b1;
      hit = 1'b0;
      i = hint_model;
      while (!hit && i + r <= n) begin
        if (frames_model[i] == 0) begin
          j = 0;
          while (j < r && frames_model[i+j] == 0) j++;
          if (j < r) begin
            first = 1'b0;
            i += j + 1;
          end else begin
            for (j = 0; j < r; j++) frames_model[i+j] = 8'd1;
            if (first) hint_model = 13'(i + r);
            o.result_frame = FRAME_W'(base_model + i);
            hit = 1'b1;
          end
        end else begin
          i++;
        end
      end
      o.status = hit ? ST_OK : ST_NO_RUN;
      return o;
    end
    if (q.frame_number < base_model || q.frame_number - base_model >= n ||
        int'(q.frame_number - base_model) + r > n) begin
      o.status = ST_RANGE;
      return o;
    end
    idx = q.frame_number - base_model;
    if (q.kind == KIND_QUERY) begin
      o.user_count = frames_model[idx][6:0];
      o.cow_flag = frames_model[idx][7];
      return o;
    end
    if (q.kind == KIND_RESERVE) begin
      for (j = 0; j < r; j++) frames_model[idx+j] = 8'd127;
      return o;
    end
    for (j = 0; j < r; j++) begin
      c = frames_model[idx+j][6:0];
      if (c == 0) begin
        o.status = ST_UNUSED;
        return o;
      end
      if (q.kind == KIND_ADDREF && c == USER_LIMIT) begin
        o.status = ST_SATURATED;
        return o;
      end
    end
    for (j = 0; j < r; j++) begin
      c = frames_model[idx+j][6:0];
      if (q.kind == KIND_FREE) begin
        if (c == 1) begin
          frames_model[idx+j] = 8'd0;
          if (hint_model > idx + j) hint_model = 13'(idx + j);
        end else begin
          frames_model[idx+j] = {frames_model[idx+j][7], c - 7'd1};
        end
      end else if (q.kind == KIND_ADDREF) begin
        frames_model[idx+j] = frames_model[idx+j] + 8'd1;
      end else begin
        frames_model[idx+j][7] = q.cow_value;
      end
    end
    return o;
  endfunction

  // Checks each result against the oldest prediction.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result status=%0d", rsp.status);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status);
          errors++;
        end
        if (rsp.result_frame !== e.result_frame) begin
          $error("result_frame exp %0h got %0h", e.result_frame, rsp.result_frame);
          errors++;
        end
        if (rsp.user_count !== e.user_count) begin
          $error("user_count exp %0d got %0d", e.user_count, rsp.user_count);
          errors++;
        end
        if (rsp.cow_flag !== e.cow_flag) begin
          $error("cow_flag exp %0d got %0d", e.cow_flag, rsp.cow_flag);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no request accepted and no result done.
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 200000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
    repeat (g) @(posedge clk);
  endtask

  // Sends one item and records its expected result.
  task automatic send_item(req_t q, bit gaps = 1'b1);
    if (gaps && $urandom_range(0, 3) != 0) idle_gap();
    start <= 1'b1;
    req <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(predict_request(q));
    start <= 1'b0;
    // The unit is busy after an accepted item, so this costs no throughput.
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx == REG_BASE) base_model = v[FRAME_W-1:0];
    else count_model = v[12:0];
  endtask

  function automatic req_t make_req(logic [2:0] k, logic [19:0] f, logic [4:0] r,
                                    logic c);
    req_t q;
    q.kind = k;
    q.frame_number = f;
    q.run_length = r;
    q.cow_value = c;
    return q;
  endfunction

  // Operations and special cases with default configuration.
  task automatic test_directed();
    send_item(make_req(KIND_QUERY, 20'd0, 5'd0, 1'b0));
    send_item(make_req(KIND_ALLOC, 20'd0, 5'd16, 1'b0));
    send_item(make_req(KIND_ALLOC, 20'hFFFFF, 5'd1, 1'b1));
    send_item(make_req(KIND_ALLOC, 20'd0, 5'd0, 1'b0));
    send_item(make_req(KIND_ALLOC, 20'd0, 5'd17, 1'b0));
    send_item(make_req(KIND_ADDREF, 20'd0, 5'd4, 1'b0));
    send_item(make_req(KIND_MARK, 20'd1, 5'd3, 1'b1));
    send_item(make_req(KIND_QUERY, 20'd2, 5'd31, 1'b0));
    send_item(make_req(KIND_FREE, 20'd0, 5'd16, 1'b0));
    send_item(make_req(KIND_FREE, 20'd0, 5'd16, 1'b0));
    send_item(make_req(KIND_QUERY, 20'd1, 5'd1, 1'b0));
    send_item(make_req(KIND_FREE, 20'd100, 5'd1, 1'b0));
    send_item(make_req(KIND_RESERVE, 20'd4090, 5'd6, 1'b0));
    send_item(make_req(KIND_RESERVE, 20'd4090, 5'd7, 1'b0));
    send_item(make_req(KIND_ADDREF, 20'd4094, 5'd2, 1'b0));
    send_item(make_req(KIND_QUERY, 20'd4095, 5'd1, 1'b0));
    send_item(make_req(KIND_QUERY, 20'd4096, 5'd1, 1'b0));
    send_item(make_req(3'd6, 20'd0, 5'd1, 1'b0));
    send_item(make_req(3'd7, 20'd0, 5'd1, 1'b0));
    send_item(make_req(KIND_MARK, 20'd4095, 5'd1, 1'b0));
    wait_drained();
  endtask

  // Alloc with a hole in front of the hint, then no free run at all.
  task automatic test_small_region();
    int i;
    write_reg(REG_BASE, 32'hFFFF0);
    write_reg(REG_COUNT, 32'd16);
    send_item(make_req(KIND_QUERY, 20'hFFFEF, 5'd1, 1'b0));
    for (i = 0; i < 4; i++) send_item(make_req(KIND_ALLOC, 20'd0, 5'd4, 1'b0));
    send_item(make_req(KIND_ALLOC, 20'd0, 5'd1, 1'b0));
    send_item(make_req(KIND_FREE, 20'hFFFF2, 5'd1, 1'b0));
    send_item(make_req(KIND_FREE, 20'hFFFF8, 5'd2, 1'b0));
    send_item(make_req(KIND_ALLOC, 20'd0, 5'd2, 1'b0));
    send_item(make_req(KIND_ALLOC, 20'd0, 5'd1, 1'b0));
    send_item(make_req(KIND_RESERVE, 20'hFFFF0, 5'd16, 1'b0));
    send_item(make_req(KIND_QUERY, 20'hFFFFF, 5'd1, 1'b0));
    wait_drained();
    write_reg(REG_COUNT, 32'd0);
    send_item(make_req(KIND_ALLOC, 20'd0, 5'd1, 1'b0));
    send_item(make_req(KIND_QUERY, 20'hFFFF0, 5'd1, 1'b0));
    wait_drained();
    write_reg(REG_COUNT, 32'h1FFF);
    send_item(make_req(KIND_QUERY, 20'hFFFF0, 5'd1, 1'b0));
    wait_drained();
  endtask

  // Random traffic on a configured window; mostly well-formed requests.
  task automatic test_random(int items, int cnt, logic [19:0] base);
    req_t q;
    int i, span;
    write_reg(REG_BASE, {12'd0, base});
    write_reg(REG_COUNT, cnt);
    span = managed();
    for (i = 0; i < items; i++) begin
      q.kind = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7)) :
               3'($urandom_range(0, 5));
      if (q.kind == KIND_RESERVE && $urandom_range(0, 3) != 0) q.kind = KIND_ALLOC;
      q.run_length = ($urandom_range(0, 15) == 0) ? 5'($urandom) :
                     5'($urandom_range(1, ($urandom_range(0, 4) == 0) ? 16 : 3));
      q.frame_number = ($urandom_range(0, 15) == 0) ? 20'($urandom) :
                       20'(base + $urandom_range(0, span == 0 ? 0 : span - 1));
      q.cow_value = 1'($urandom);
      send_item(q, i % 200 < 150);
      if (i == items / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (frames_model[i]) frames_model[i] = '0;
    hint_model = '0;
    base_model = '0;
    count_model = 13'd4096;
    @(posedge clk);
    test_directed();
    test_small_region();
    test_random(350, 48, 20'h00100);
    test_random(350, 200, 20'h7A5C3);
    test_random(350, 4096, 20'h00000);
    wait_drained();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/pfra_pkg.sv
hw/rtl/pfra_ram.sv
hw/rtl/pfra_datapath.sv
hw/rtl/pfra_ctrl.sv
hw/rtl/page_frame_refcount_allocator_unit.sv
sim/tb_page_frame_refcount_allocator_unit.sv
